[hdl/image_header_dimension_scanner_defines.svh]
// Assertion macros shared by the scanner RTL.
`ifndef IMAGE_HEADER_DIMENSION_SCANNER_DEFINES_SVH
`define IMAGE_HEADER_DIMENSION_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IHDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IHDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ihds_pkg.sv]
`default_nettype none

package ihds_pkg;

    typedef enum logic [2:0] {
        PH_EXPECT_FF = 3'd0,
        PH_MARKER    = 3'd1,
        PH_LEN_HI    = 3'd2,
        PH_LEN_LO    = 3'd3,
        PH_SKIP      = 3'd4,
        PH_SOF       = 3'd5
    } t_phase;

    localparam logic [1:0] FMT_PNG  = 2'd0;
    localparam logic [1:0] FMT_JPEG = 2'd1;

    localparam logic [7:0] PNG_SIG [8] = '{
        8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
    };
    localparam logic [7:0] IHDR_TAG [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

    localparam int          PNG_MIN_BYTES  = 8 + 8 + 13 + 4;
    localparam logic [5:0]  PNG_SIG_END    = 6'd8;
    localparam logic [5:0]  PNG_TAG_POS    = 6'd12;
    localparam logic [5:0]  PNG_WIDTH_POS  = 6'd16;
    localparam logic [5:0]  PNG_HEIGHT_POS = 6'd20;
    localparam logic [5:0]  PNG_HEIGHT_END = 6'd24;
    localparam logic [5:0]  PNG_DONE_POS   = 6'(PNG_MIN_BYTES - 1);

    localparam logic [7:0]  MRK_FILL = 8'hff;
    localparam logic [7:0]  MRK_NUL  = 8'h00;
    localparam logic [7:0]  MRK_RST0 = 8'hd0;
    localparam logic [7:0]  MRK_EOI  = 8'hd9;
    localparam logic [7:0]  MRK_SOF0 = 8'hc0;
    localparam logic [7:0]  MRK_SOF2 = 8'hc2;

    localparam logic [5:0]  SOF_HEIGHT_HI = 6'd4;
    localparam logic [5:0]  SOF_HEIGHT_LO = 6'd5;
    localparam logic [5:0]  SOF_WIDTH_HI  = 6'd6;
    localparam logic [5:0]  SOF_WIDTH_LO  = 6'd7;
    localparam logic [5:0]  SOF_DONE      = 6'd8;

    localparam logic [15:0] SEG_LEN_MIN = 16'd2;

    typedef struct packed {
        logic        found;
        logic [31:0] width;
        logic [31:0] height;
    } t_result;

endpackage

`default_nettype wire

[hdl/ihds_ifs.sv]
`default_nettype none

interface ihds_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ihds_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] width;
    logic [31:0] height;

    modport source (output valid, output found, output width, output height, input ready);
    modport sink (input valid, input found, input width, input height, output ready);
endinterface

`default_nettype wire

[hdl/ihds_parser.sv]
`default_nettype none
`include "image_header_dimension_scanner_defines.svh"

module ihds_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_final,
    input  wire logic [1:0]        i_format,
    output ihds_pkg::t_result      o_result,
    output logic                   o_emit
);

    ihds_pkg::t_phase r_phase, n_phase;
    logic [5:0]       r_pos, n_pos;
    logic [15:0]      r_skip, n_skip;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [31:0]      r_width, n_width;
    logic [31:0]      r_height, n_height;
    logic             r_answered, n_answered;

    logic             decided;
    logic             ok;
    logic [15:0]      seg_len;
    logic [5:0]       sof_pos;

    assign seg_len = {r_len_hi, i_byte};
    assign sof_pos = r_pos + 6'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ihds_pkg::PH_EXPECT_FF;
            r_pos      <= '0;
            r_skip     <= '0;
            r_len_hi   <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_answered <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_skip     <= n_skip;
            r_len_hi   <= n_len_hi;
            r_width    <= n_width;
            r_height   <= n_height;
            r_answered <= n_answered;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_skip     = r_skip;
        n_len_hi   = r_len_hi;
        n_width    = r_width;
        n_height   = r_height;
        n_answered = r_answered;
        decided    = 1'b0;
        ok         = 1'b0;

        if (!r_answered) begin
            case (i_format)
                ihds_pkg::FMT_PNG: begin
                    if (r_pos >= ihds_pkg::PNG_DONE_POS) begin
                        decided = 1'b1;
                        ok      = 1'b1;
                    end else if (r_pos < ihds_pkg::PNG_SIG_END) begin
                        decided = (i_byte != ihds_pkg::PNG_SIG[r_pos[2:0]]);
                    end else if (r_pos >= ihds_pkg::PNG_TAG_POS &&
                                 r_pos < ihds_pkg::PNG_WIDTH_POS) begin
                        decided = (i_byte != ihds_pkg::IHDR_TAG[r_pos[1:0]]);
                    end else if (r_pos >= ihds_pkg::PNG_WIDTH_POS &&
                                 r_pos < ihds_pkg::PNG_HEIGHT_POS) begin
                        n_width = {r_width[23:0], i_byte};
                    end else if (r_pos >= ihds_pkg::PNG_HEIGHT_POS &&
                                 r_pos < ihds_pkg::PNG_HEIGHT_END) begin
                        n_height = {r_height[23:0], i_byte};
                    end
                    if (!decided) begin
                        n_pos = r_pos + 6'd1;
                    end
                end
                ihds_pkg::FMT_JPEG: begin
                    unique case (r_phase)
                        ihds_pkg::PH_MARKER: begin
                            if (i_byte == ihds_pkg::MRK_FILL) begin
                                n_phase = ihds_pkg::PH_MARKER;
                            end else if (i_byte == ihds_pkg::MRK_NUL ||
                                         (i_byte >= ihds_pkg::MRK_RST0 &&
                                          i_byte <= ihds_pkg::MRK_EOI)) begin
                                n_phase = ihds_pkg::PH_EXPECT_FF;
                            end else if (i_byte == ihds_pkg::MRK_SOF0 ||
                                         i_byte == ihds_pkg::MRK_SOF2) begin
                                n_phase  = ihds_pkg::PH_SOF;
                                n_pos    = '0;
                                n_width  = '0;
                                n_height = '0;
                            end else begin
                                n_phase = ihds_pkg::PH_LEN_HI;
                            end
                        end
                        ihds_pkg::PH_LEN_HI: begin
                            n_len_hi = i_byte;
                            n_phase  = ihds_pkg::PH_LEN_LO;
                        end
                        ihds_pkg::PH_LEN_LO: begin
                            if (seg_len < ihds_pkg::SEG_LEN_MIN) begin
                                decided = 1'b1;
                            end else begin
                                n_skip  = seg_len - ihds_pkg::SEG_LEN_MIN;
                                n_phase = (seg_len == ihds_pkg::SEG_LEN_MIN) ?
                                          ihds_pkg::PH_EXPECT_FF : ihds_pkg::PH_SKIP;
                            end
                        end
                        ihds_pkg::PH_SKIP: begin
                            if (r_skip <= 16'd1) begin
                                n_skip  = '0;
                                n_phase = ihds_pkg::PH_EXPECT_FF;
                            end else begin
                                n_skip = r_skip - 16'd1;
                            end
                        end
                        ihds_pkg::PH_SOF: begin
                            n_pos = sof_pos;
                            if (sof_pos == ihds_pkg::SOF_HEIGHT_HI ||
                                sof_pos == ihds_pkg::SOF_HEIGHT_LO) begin
                                n_height = {16'd0, r_height[7:0], i_byte};
                            end else if (sof_pos == ihds_pkg::SOF_WIDTH_HI ||
                                         sof_pos == ihds_pkg::SOF_WIDTH_LO) begin
                                n_width = {16'd0, r_width[7:0], i_byte};
                            end else if (sof_pos >= ihds_pkg::SOF_DONE) begin
                                decided = 1'b1;
                                ok      = 1'b1;
                            end
                        end
                        default: begin
                            if (i_byte != ihds_pkg::MRK_FILL) begin
                                decided = 1'b1;
                            end else begin
                                n_phase = ihds_pkg::PH_MARKER;
                            end
                        end
                    endcase
                end
                default: begin
                    decided = 1'b1;
                end
            endcase
            if (decided) begin
                n_answered = 1'b1;
            end
        end

        o_emit          = decided || (i_final && !r_answered);
        o_result.found  = decided && ok;
        o_result.width  = (decided && ok) ? r_width : '0;
        o_result.height = (decided && ok) ? r_height : '0;

        if (i_final) begin
            n_phase    = ihds_pkg::PH_EXPECT_FF;
            n_pos      = '0;
            n_skip     = '0;
            n_len_hi   = '0;
            n_width    = '0;
            n_height   = '0;
            n_answered = 1'b0;
        end
    end

    `IHDS_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, i_step && i_final,
        r_phase == ihds_pkg::PH_EXPECT_FF && r_pos == 6'd0 && !r_answered,
        "Per-file state was not cleared after the final beat.")
    `IHDS_ASSERT_NOW(a_one_answer, i_clk, i_rst_n, i_step && r_answered && !i_final,
        !o_emit, "A second result was produced for one file.")
    `IHDS_ASSERT_NOW(a_other_fails, i_clk, i_rst_n,
        i_step && !r_answered && i_format != ihds_pkg::FMT_PNG &&
        i_format != ihds_pkg::FMT_JPEG,
        o_emit && !o_result.found, "An unsupported format did not fail at once.")

endmodule

`default_nettype wire

[hdl/image_header_dimension_scanner.sv]
// Image header dimension scanner. Stream the bytes of one file, one beat per byte, with
// final_byte set on the last one; exactly one result beat per file comes back, giving found
// and the raw width and height (zero on failure). image_format selects PNG (0), JPEG (1) or
// any other format, which fails on the first byte; write it only between files. The block
// takes one byte every cycle while the result register is not blocked: each beat passes an
// input register, then the parser updates its state and fills the result register. Input
// ready falls only while the result register holds a beat the sink has not taken; the
// parser's state update per byte is what sets the rate of one byte per cycle.
`default_nettype none
`include "image_header_dimension_scanner_defines.svh"

module image_header_dimension_scanner (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [1:0] i_cfg_wr_data,
    ihds_byte_if.sink       i_byte_stream,
    ihds_result_if.source   o_result
);

    logic              r_fmt;
    logic [1:0]        r_format;
    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    logic              r_s1_final;
    logic              r_o_valid;
    ihds_pkg::t_result r_o_result;

    logic              out_free;
    logic              s2_go;
    logic              emit;
    ihds_pkg::t_result result;

    assign out_free            = !r_o_valid || o_result.ready;
    assign s2_go               = r_s1_valid && out_free;
    assign i_byte_stream.ready = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= ihds_pkg::FMT_PNG;
            r_fmt    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_format <= i_cfg_wr_data;
            r_fmt    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte_stream.ready) begin
            r_s1_valid <= i_byte_stream.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_stream.ready && i_byte_stream.valid) begin
            r_s1_byte  <= i_byte_stream.data_byte;
            r_s1_final <= i_byte_stream.final_byte;
        end
    end

    ihds_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s2_go),
        .i_byte   (r_s1_byte),
        .i_final  (r_s1_final),
        .i_format (r_format),
        .o_result (result),
        .o_emit   (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s2_go && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && emit) begin
            r_o_result <= result;
        end
    end

    assign o_result.valid  = r_o_valid;
    assign o_result.found  = r_o_result.found;
    assign o_result.width  = r_o_result.width;
    assign o_result.height = r_o_result.height;

    `IHDS_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, r_o_valid && !r_o_result.found,
        r_o_result.width == 32'd0 && r_o_result.height == 32'd0,
        "A failure result carries nonzero dimensions.")
    `IHDS_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, r_s1_valid && !out_free,
        r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_final),
        "A held input beat was lost while the result register was blocked.")
    `IHDS_ASSERT_NEXT(a_cfg_written, i_clk, i_rst_n, i_cfg_wr_en,
        r_fmt && r_format == $past(i_cfg_wr_data),
        "The format register did not take the written value.")

endmodule

`default_nettype wire
